// File: rtl/core/cdcnt_pkg.sv
// ============================================================================
// cdcnt_pkg
// Shared types, constants and calendar helper functions for the date counter.
// ============================================================================
package cdcnt_pkg;

    localparam int CDCNT_JUMP_BITS = 16;

    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_MIN  = 4'd1;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [13:0] RST_YEAR   = 14'd2000;
    localparam logic [6:0]  RST_CENT   = 7'd20;
    localparam logic [6:0]  RST_YY     = 7'd0;
    localparam logic [3:0]  RST_MONTH  = 4'd1;
    localparam logic [4:0]  RST_DAY    = 5'd1;

    // floor(y / 100) == (y * RECIP_100) >> 19 for y < 10000
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    // floor(s / 7) == (s * RECIP_7) >> 14 for s < 1024
    localparam logic [11:0] RECIP_7    = 12'd2341;
    localparam int          RECIP_7_SHIFT = 14;
    localparam logic [9:0]  WDAY_OFFSET = 10'd5;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_NEXT = 3'd1,
        OP_PREV = 3'd2,
        OP_FWD  = 3'd3,
        OP_BACK = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_SPLIT,
        S_LD_DAY,
        S_WALK,
        S_SUM,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic ld_start;
        logic ld_split;
        logic ld_day;
        logic walk_start;
        logic walk_fwd;
        logic walk_unit;
        logic walk_step;
        logic sum;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
    } t_dp_sts;

    function automatic logic f_leap(input logic [6:0] cent, input logic [6:0] yy);
        if (yy == 7'd0) begin
            return cent[1:0] == 2'b00;
        end else begin
            return yy[1:0] == 2'b00;
        end
    endfunction

    function automatic logic [4:0] f_month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            4'd2:    days = leap ? 5'd29 : 5'd28;
            4'd4:    days = 5'd30;
            4'd6:    days = 5'd30;
            4'd9:    days = 5'd30;
            4'd11:   days = 5'd30;
            default: days = 5'd31;
        endcase
        return days;
    endfunction

    // floor(13 * (m + 1) / 5) for the shifted month 3..14
    function automatic logic [5:0] f_zel_month(input logic [3:0] month);
        logic [5:0] term;
        case (month)
            4'd3:    term = 6'd10;
            4'd4:    term = 6'd13;
            4'd5:    term = 6'd15;
            4'd6:    term = 6'd18;
            4'd7:    term = 6'd20;
            4'd8:    term = 6'd23;
            4'd9:    term = 6'd26;
            4'd10:   term = 6'd28;
            4'd11:   term = 6'd31;
            4'd12:   term = 6'd33;
            4'd13:   term = 6'd36;
            4'd14:   term = 6'd39;
            default: term = 6'd0;
        endcase
        return term;
    endfunction

endpackage

// File: rtl/core/cdcnt_if.sv
// ============================================================================
// cdcnt_if
// Valid/ready channels for date counter commands and results.
// ============================================================================
interface cdcnt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] jump_days;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;

    modport source (output valid, op, jump_days, load_year, load_month, load_day,
                    input ready);
    modport sink   (input valid, op, jump_days, load_year, load_month, load_day,
                    output ready);
endinterface

interface cdcnt_res_if;
    logic        valid;
    logic        ready;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday;
    logic        leap_year;
    logic [4:0]  month_length;

    modport source (output valid, year_out, month_out, day_out, weekday, leap_year,
                    month_length, input ready);
    modport sink   (input valid, year_out, month_out, day_out, weekday, leap_year,
                    month_length, output ready);
endinterface

// File: rtl/core/cdcnt_dp.sv
// ============================================================================
// cdcnt_dp
// Date datapath: date registers, month walker, load split and weekday unit.
// ============================================================================
module cdcnt_dp import cdcnt_pkg::*; #(
    parameter int JUMP_BITS = CDCNT_JUMP_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [15:0] i_jump_days,
    input  logic [13:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    output logic [13:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [2:0]  o_weekday,
    output logic        o_leap_year,
    output logic [4:0]  o_month_length
);

    logic [13:0]          r_year, n_year;
    logic [6:0]           r_cent, n_cent;
    logic [6:0]           r_yy, n_yy;
    logic [3:0]           r_month, n_month;
    logic [4:0]           r_day, n_day;
    logic [JUMP_BITS-1:0] r_n;
    logic                 r_fwd;
    logic [25:0]          r_prod;
    logic [9:0]           r_sum;

    logic [13:0] clamp_year;
    logic [3:0]  clamp_month;
    logic        leap_cur;
    logic [4:0]  len_cur;
    logic [6:0]  split_cent;
    logic [13:0] split_rem;
    logic [4:0]  ld_day;

    logic [13:0] nf_year, nb_year;
    logic [6:0]  nf_cent, nf_yy, nb_cent, nb_yy;
    logic [3:0]  nf_month, nb_month;
    logic [4:0]  nb_len;
    logic        fwd_over, back_over;

    logic [3:0]  z_month;
    logic [6:0]  z_k, z_j;
    logic [9:0]  z_sum;
    logic [9:0]  s5;
    logic [21:0] prod7;
    logic [6:0]  q7;
    logic [2:0]  wday;

    always_comb begin
        clamp_year = i_load_year;
        if (i_load_year < YEAR_MIN) clamp_year = YEAR_MIN;
        if (i_load_year > YEAR_MAX) clamp_year = YEAR_MAX;
        clamp_month = i_load_month;
        if (i_load_month < MONTH_MIN) clamp_month = MONTH_MIN;
        if (i_load_month > MONTH_MAX) clamp_month = MONTH_MAX;
    end

    assign leap_cur   = f_leap(r_cent, r_yy);
    assign len_cur    = f_month_days(r_month, leap_cur);
    assign split_cent = r_prod[RECIP_100_SHIFT+6:RECIP_100_SHIFT];
    assign split_rem  = r_year - 14'(split_cent) * 14'd100;

    always_comb begin
        ld_day = r_n[4:0];
        if (ld_day == 5'd0) ld_day = 5'd1;
        if (ld_day > len_cur) ld_day = len_cur;
    end

    // month walk neighbors
    always_comb begin
        nf_year  = r_year;
        nf_cent  = r_cent;
        nf_yy    = r_yy;
        nf_month = r_month + 4'd1;
        if (r_month >= MONTH_MAX) begin
            nf_month = MONTH_MIN;
            if (r_year >= YEAR_MAX) begin
                nf_year = YEAR_MIN;
                nf_cent = 7'd0;
                nf_yy   = 7'd1;
            end else begin
                nf_year = r_year + 14'd1;
                if (r_yy == 7'd99) begin
                    nf_yy   = 7'd0;
                    nf_cent = r_cent + 7'd1;
                end else begin
                    nf_yy = r_yy + 7'd1;
                end
            end
        end

        nb_year  = r_year;
        nb_cent  = r_cent;
        nb_yy    = r_yy;
        nb_month = r_month - 4'd1;
        if (r_month <= MONTH_MIN) begin
            nb_month = MONTH_MAX;
            if (r_year <= YEAR_MIN) begin
                nb_year = YEAR_MAX;
                nb_cent = 7'd99;
                nb_yy   = 7'd99;
            end else begin
                nb_year = r_year - 14'd1;
                if (r_yy == 7'd0) begin
                    nb_yy   = 7'd99;
                    nb_cent = r_cent - 7'd1;
                end else begin
                    nb_yy = r_yy - 7'd1;
                end
            end
        end
        nb_len = f_month_days(nb_month, f_leap(nb_cent, nb_yy));
    end

    assign fwd_over  = ({1'b0, r_n} + (JUMP_BITS+1)'(r_day)) > (JUMP_BITS+1)'(len_cur);
    assign back_over = r_n >= JUMP_BITS'(r_day);
    assign o_sts.walk_done = r_fwd ? !fwd_over : !back_over;

    always_comb begin
        n_year  = r_year;
        n_cent  = r_cent;
        n_yy    = r_yy;
        n_month = r_month;
        n_day   = r_day;
        if (i_cmd.ld_start) begin
            n_year  = clamp_year;
            n_month = clamp_month;
        end
        if (i_cmd.ld_split) begin
            n_cent = split_cent;
            n_yy   = split_rem[6:0];
        end
        if (i_cmd.ld_day) begin
            n_day = ld_day;
        end
        if (i_cmd.walk_step) begin
            if (r_fwd) begin
                if (fwd_over) begin
                    n_year  = nf_year;
                    n_cent  = nf_cent;
                    n_yy    = nf_yy;
                    n_month = nf_month;
                    n_day   = 5'd1;
                end else begin
                    n_day = r_day + r_n[4:0];
                end
            end else begin
                if (back_over) begin
                    n_year  = nb_year;
                    n_cent  = nb_cent;
                    n_yy    = nb_yy;
                    n_month = nb_month;
                    n_day   = nb_len;
                end else begin
                    n_day = r_day - r_n[4:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= RST_YEAR;
            r_cent  <= RST_CENT;
            r_yy    <= RST_YY;
            r_month <= RST_MONTH;
            r_day   <= RST_DAY;
        end else begin
            r_year  <= n_year;
            r_cent  <= n_cent;
            r_yy    <= n_yy;
            r_month <= n_month;
            r_day   <= n_day;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_start) begin
            r_prod <= 26'(clamp_year) * 26'(RECIP_100);
            r_n    <= JUMP_BITS'(i_load_day);
        end
        if (i_cmd.walk_start) begin
            r_fwd <= i_cmd.walk_fwd;
            r_n   <= i_cmd.walk_unit ? JUMP_BITS'(1) : JUMP_BITS'(i_jump_days);
        end
        if (i_cmd.walk_step) begin
            if (r_fwd && fwd_over) begin
                r_n <= r_n - JUMP_BITS'(len_cur - r_day + 5'd1);
            end else if (!r_fwd && back_over) begin
                r_n <= r_n - JUMP_BITS'(r_day);
            end
        end
        if (i_cmd.sum) begin
            r_sum <= z_sum;
        end
    end

    // Zeller terms; January and February count as months 13 and 14 of the prior year
    always_comb begin
        z_month = r_month;
        z_k     = r_yy;
        z_j     = r_cent;
        if (r_month < 4'd3) begin
            z_month = r_month + 4'd12;
            if (r_yy == 7'd0) begin
                z_k = 7'd99;
                z_j = r_cent - 7'd1;
            end else begin
                z_k = r_yy - 7'd1;
            end
        end
        z_sum = 10'(r_day) + 10'(f_zel_month(z_month)) + 10'(z_k) + 10'(z_k[6:2])
              + 10'(z_j[6:2]) + 10'(z_j) * 10'd5;
    end

    assign s5    = r_sum + WDAY_OFFSET;
    assign prod7 = 22'(s5) * 22'(RECIP_7);
    assign q7    = prod7[RECIP_7_SHIFT+6:RECIP_7_SHIFT];
    assign wday  = 3'(s5 - 10'(q7) * 10'd7);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_year_out     <= r_year;
            o_month_out    <= r_month;
            o_day_out      <= r_day;
            o_weekday      <= wday;
            o_leap_year    <= leap_cur;
            o_month_length <= len_cur;
        end
    end

endmodule

// File: rtl/core/cdcnt_ctrl.sv
// ============================================================================
// cdcnt_ctrl
// Command sequencer: accepts a transaction, steps the datapath, owns result valid.
// ============================================================================
module cdcnt_ctrl import cdcnt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_op,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   push_ok;

    assign push_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_op))
                        OP_LOAD: n_state = S_LD_SPLIT;
                        OP_NEXT: n_state = S_WALK;
                        OP_PREV: n_state = S_WALK;
                        OP_FWD:  n_state = S_WALK;
                        OP_BACK: n_state = S_WALK;
                        default: n_state = S_SUM;
                    endcase
                end
            end
            S_LD_SPLIT: n_state = S_LD_DAY;
            S_LD_DAY:   n_state = S_SUM;
            S_WALK: begin
                if (i_sts.walk_done) n_state = S_SUM;
            end
            S_SUM:      n_state = S_PUSH;
            S_PUSH: begin
                if (push_ok) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_op))
                        OP_LOAD: o_cmd.ld_start = 1'b1;
                        OP_NEXT: begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_fwd   = 1'b1;
                            o_cmd.walk_unit  = 1'b1;
                        end
                        OP_PREV: begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_unit  = 1'b1;
                        end
                        OP_FWD: begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_fwd   = 1'b1;
                        end
                        OP_BACK: o_cmd.walk_start = 1'b1;
                        default: o_cmd = '0;
                    endcase
                end
            end
            S_LD_SPLIT: o_cmd.ld_split  = 1'b1;
            S_LD_DAY:   o_cmd.ld_day    = 1'b1;
            S_WALK:     o_cmd.walk_step = 1'b1;
            S_SUM:      o_cmd.sum       = 1'b1;
            S_PUSH:     o_cmd.push      = push_ok;
            default:    o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/calendar_date_counter_top.sv
// ============================================================================
// calendar_date_counter_top
// Gregorian date counter with load, day step, day jump and weekday report.
// ============================================================================
// One command transaction at a time. After acceptance, a load passes through
// the states LD_SPLIT, LD_DAY, SUM and PUSH, an unused op code through SUM and
// PUSH, and a step or jump through WALK, SUM and PUSH; the month walker crosses
// one month boundary per cycle. A finished result sits in an output register,
// and the next command is accepted while it waits to be taken.
module calendar_date_counter_top import cdcnt_pkg::*; #(
    parameter int JUMP_BITS = CDCNT_JUMP_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cdcnt_cmd_if.sink   i_cmd,
    cdcnt_res_if.source o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    cdcnt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_op        (i_cmd.op),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    cdcnt_dp #(
        .JUMP_BITS (JUMP_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_jump_days    (i_cmd.jump_days),
        .i_load_year    (i_cmd.load_year),
        .i_load_month   (i_cmd.load_month),
        .i_load_day     (i_cmd.load_day),
        .o_year_out     (o_res.year_out),
        .o_month_out    (o_res.month_out),
        .o_day_out      (o_res.day_out),
        .o_weekday      (o_res.weekday),
        .o_leap_year    (o_res.leap_year),
        .o_month_length (o_res.month_length)
    );

    assign i_cmd.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

    a_day_in_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.day_out != 5'd0) && (o_res.day_out <= o_res.month_length))
        else $error("result day outside its month");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.month_out >= MONTH_MIN) && (o_res.month_out <= MONTH_MAX)
                        && (o_res.year_out >= YEAR_MIN) && (o_res.year_out <= YEAR_MAX))
        else $error("result month or year out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted while previous one in progress");

    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> o_res.valid)
        else $error("result register loaded without valid");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the calendar date counter. Commands go in on the
// command channel and every result is compared field by field against a
// date predictor kept in a scoreboard class. A short directed set covers the
// clamping, wrap and unused-code corners. Random traffic follows, with idle
// bursts on both channels and one long result hold-off.
// ============================================================================
module tb_top;
    import cdcnt_pkg::*;

    localparam int          RANDOM_ITEMS  = 880;
    localparam int          CYCLE_LIMIT   = 8_000_000;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          HOLD_AT_ITEM  = 300;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [2:0]  OP_CODE_LAST  = 3'd7;
    localparam logic [13:0] YEAR_FIELD_MAX = 14'h3FFF;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic        leap;
        logic [4:0]  month_len;
    } t_date_report;

    class date_scoreboard;
        int unsigned  cur_year;
        int unsigned  cur_month;
        int unsigned  cur_day;
        t_date_report expected_dates[$];
        int           mismatches;
        int           checked;

        function new();
            cur_year   = RST_YEAR;
            cur_month  = RST_MONTH;
            cur_day    = RST_DAY;
            mismatches = 0;
            checked    = 0;
        endfunction

        function bit is_leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(int unsigned m, int unsigned y);
            int unsigned lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (m < 1 || m > 12) begin
                return 31;
            end
            if (m == 2 && is_leap_year(y)) begin
                return 29;
            end
            return lens[m];
        endfunction

        function int unsigned day_of_week(int unsigned d, int unsigned m, int unsigned y);
            int unsigned k;
            int unsigned j;
            int unsigned h;
            if (m < 3) begin
                m += 12;
                y -= 1;
            end
            k = y % 100;
            j = y / 100;
            h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
            return (h + 5) % 7;
        endfunction

        function void advance_month();
            cur_month++;
            if (cur_month > 12) begin
                cur_month = 1;
                cur_year  = (cur_year >= YEAR_MAX) ? YEAR_MIN : cur_year + 1;
            end
        endfunction

        function void retreat_month();
            if (cur_month <= 1) begin
                cur_month = 12;
                cur_year  = (cur_year <= YEAR_MIN) ? YEAR_MAX : cur_year - 1;
            end else begin
                cur_month--;
            end
        endfunction

        function void walk_forward(int unsigned n);
            int unsigned len;
            len = days_in_month(cur_month, cur_year);
            while (n + cur_day > len) begin
                n -= len - cur_day + 1;
                advance_month();
                cur_day = 1;
                len = days_in_month(cur_month, cur_year);
            end
            cur_day += n;
        endfunction

        function void walk_backward(int unsigned n);
            while (n >= cur_day) begin
                n -= cur_day;
                retreat_month();
                cur_day = days_in_month(cur_month, cur_year);
            end
            cur_day -= n;
        endfunction

        function void note_command(logic [2:0] op, logic [15:0] jump, logic [13:0] ld_year,
                                   logic [3:0] ld_month, logic [4:0] ld_day);
            int unsigned  n;
            int unsigned  y;
            int unsigned  m;
            int unsigned  d;
            int unsigned  len;
            t_date_report rpt;
            n = int'(jump) & ((1 << CDCNT_JUMP_BITS) - 1);
            case (op)
                OP_LOAD: begin
                    y = ld_year;
                    m = ld_month;
                    d = ld_day;
                    if (y < YEAR_MIN) y = YEAR_MIN;
                    if (y > YEAR_MAX) y = YEAR_MAX;
                    if (m < MONTH_MIN) m = MONTH_MIN;
                    if (m > MONTH_MAX) m = MONTH_MAX;
                    len = days_in_month(m, y);
                    if (d < 1) d = 1;
                    if (d > len) d = len;
                    cur_year  = y;
                    cur_month = m;
                    cur_day   = d;
                end
                OP_NEXT: walk_forward(1);
                OP_PREV: walk_backward(1);
                OP_FWD:  walk_forward(n);
                OP_BACK: walk_backward(n);
                default: ;
            endcase
            rpt.year      = cur_year[13:0];
            rpt.month     = cur_month[3:0];
            rpt.day       = cur_day[4:0];
            rpt.weekday   = 3'(day_of_week(cur_day, cur_month, cur_year));
            rpt.leap      = is_leap_year(cur_year);
            rpt.month_len = 5'(days_in_month(cur_month, cur_year));
            expected_dates.push_back(rpt);
        endfunction

        function void check_report(t_date_report got);
            t_date_report exp_rpt;
            checked++;
            if (expected_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result %0d-%0d-%0d wd %0d leap %0d len %0d",
                             $realtime, got.year, got.month, got.day, got.weekday,
                             got.leap, got.month_len);
                end
                return;
            end
            exp_rpt = expected_dates.pop_front();
            if (got.year !== exp_rpt.year || got.month !== exp_rpt.month ||
                got.day !== exp_rpt.day || got.weekday !== exp_rpt.weekday ||
                got.leap !== exp_rpt.leap || got.month_len !== exp_rpt.month_len) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] mismatch: exp %0d-%0d-%0d wd %0d leap %0d len %0d",
                             $realtime, exp_rpt.year, exp_rpt.month, exp_rpt.day,
                             exp_rpt.weekday, exp_rpt.leap, exp_rpt.month_len);
                    $display("               got %0d-%0d-%0d wd %0d leap %0d len %0d",
                             got.year, got.month, got.day, got.weekday, got.leap,
                             got.month_len);
                end
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cdcnt_cmd_if cmd_if ();
    cdcnt_res_if res_if ();

    date_scoreboard sb;

    int  cmds_sent;
    int  load_count;
    int  step_count;
    int  jump_count;
    int  unused_count;
    int  cycle_count = 0;
    bit  hold_req;
    bit  quiet;

    calendar_date_counter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_report('{res_if.year_out, res_if.month_out, res_if.day_out,
                              res_if.weekday, res_if.leap_year, res_if.month_length});
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    res_if.ready <= 1'b1;
                end
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 9);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_command(input logic [2:0] op, input logic [15:0] jump,
                                input logic [13:0] ld_year, input logic [3:0] ld_month,
                                input logic [4:0] ld_day);
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.jump_days  <= jump;
        cmd_if.load_year  <= ld_year;
        cmd_if.load_month <= ld_month;
        cmd_if.load_day   <= ld_day;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_command(op, jump, ld_year, ld_month, ld_day);
        cmds_sent++;
        case (op)
            OP_LOAD:          load_count++;
            OP_NEXT, OP_PREV: step_count++;
            OP_FWD, OP_BACK:  jump_count++;
            default:          unused_count++;
        endcase
        if (cmds_sent == HOLD_AT_ITEM) begin
            hold_req = 1'b1;
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_command();
        int          pick;
        int          span;
        logic [2:0]  op;
        logic [15:0] jump;
        logic [13:0] ld_year;
        logic [3:0]  ld_month;
        logic [4:0]  ld_day;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 99);
        if (pick < 15)      op = OP_LOAD;
        else if (pick < 35) op = OP_NEXT;
        else if (pick < 55) op = OP_PREV;
        else if (pick < 75) op = OP_FWD;
        else if (pick < 95) op = OP_BACK;
        else                op = 3'($urandom_range(OP_BACK + 1, OP_CODE_LAST));
        if (span < 85)      jump = 16'($urandom_range(0, 400));
        else if (span < 97) jump = 16'($urandom_range(0, 5000));
        else                jump = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 4) == 0) begin
            ld_year  = 14'($urandom_range(0, YEAR_FIELD_MAX));
            ld_month = 4'($urandom_range(0, 15));
            ld_day   = 5'($urandom_range(0, 31));
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                ld_year = $urandom_range(0, 1) ? 14'($urandom_range(1, 3))
                                               : 14'($urandom_range(9997, 9999));
            end else begin
                ld_year = 14'($urandom_range(YEAR_MIN, YEAR_MAX));
            end
            ld_month = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
            ld_day   = 5'($urandom_range(1, 31));
        end
        send_command(op, jump, ld_year, ld_month, ld_day);
    endtask

    initial begin
        sb           = new();
        cmds_sent    = 0;
        load_count   = 0;
        step_count   = 0;
        jump_count   = 0;
        unused_count = 0;
        hold_req     = 1'b0;
        quiet        = 1'b0;
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.op         <= OP_LOAD;
        cmd_if.jump_days  <= '0;
        cmd_if.load_year  <= '0;
        cmd_if.load_month <= '0;
        cmd_if.load_day   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // report the reset date, then clamp corners
        send_command(OP_CODE_LAST, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_LOAD, 16'hFFFF, 14'd0, 4'd0, 5'd0);
        send_command(OP_LOAD, 16'd0, YEAR_FIELD_MAX, 4'd15, 5'd31);
        send_command(OP_LOAD, 16'd0, 14'd10000, 4'd13, 5'd31);
        send_command(OP_LOAD, 16'd0, 14'd2000, 4'd2, 5'd31);
        send_command(OP_LOAD, 16'd0, 14'd1900, 4'd2, 5'd30);
        send_command(OP_LOAD, 16'd0, 14'd2023, 4'd4, 5'd31);
        // year wrap forward and back
        send_command(OP_LOAD, 16'd0, YEAR_MAX, 4'd12, 5'd31);
        send_command(OP_NEXT, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_PREV, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_LOAD, 16'd0, YEAR_MIN, 4'd1, 5'd1);
        send_command(OP_PREV, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_NEXT, 16'd0, 14'd0, 4'd0, 5'd0);
        // month and century edges
        send_command(OP_LOAD, 16'd0, 14'd2100, 4'd2, 5'd28);
        send_command(OP_NEXT, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_LOAD, 16'd0, 14'd2024, 4'd2, 5'd28);
        send_command(OP_NEXT, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_NEXT, 16'd0, 14'd0, 4'd0, 5'd0);
        // zero, short and maximum jumps
        send_command(OP_FWD, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_BACK, 16'd0, 14'd0, 4'd0, 5'd0);
        send_command(OP_FWD, 16'd366, 14'd0, 4'd0, 5'd0);
        send_command(OP_FWD, 16'hFFFF, 14'd0, 4'd0, 5'd0);
        send_command(OP_BACK, 16'hFFFF, 14'd0, 4'd0, 5'd0);
        send_command(3'd5, 16'd12, 14'd5, 4'd5, 5'd5);
        send_command(3'd6, 16'd12, 14'd5, 4'd5, 5'd5);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= (RANDOM_ITEMS * 9) / 10) begin
                quiet = 1'b1;
            end
            send_random_command();
        end
        cmd_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands: %0d loads, %0d day steps, %0d jumps, %0d unused codes",
                 cmds_sent, load_count, step_count, jump_count, unused_count);
        $display("Results compared: %0d, mismatches: %0d, outstanding: %0d",
                 sb.checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/cdcnt_pkg.sv
rtl/core/cdcnt_if.sv
rtl/core/cdcnt_dp.sv
rtl/core/cdcnt_ctrl.sv
rtl/core/calendar_date_counter_top.sv
verif/tb_top.sv
